// File: hw/rtl/wsce_pkg.sv
// shared types and constants of the websocket client frame encoder
// no dependencies
package wsce_pkg;

    localparam logic [15:0] MAX_FRAME_BYTES = 16'd1024;
    localparam logic [15:0] LEN_SHORT_MAX   = 16'd125;
    localparam logic [6:0]  LEN_EXT_CODE    = 7'd126;
    localparam logic [15:0] HDR_BYTES       = 16'd6;
    localparam logic [15:0] HDR_EXT_BYTES   = 16'd8;
    localparam logic [7:0]  HDR_FLAG        = 8'h80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one queued job: optional header burst, then an optional payload byte
    typedef struct packed {
        logic        start;
        logic [3:0]  opcode;
        logic [15:0] payload_length;
        logic [31:0] mask_key;
        logic        ext;
        logic        hdr_last;
        logic        has_data;
        logic [7:0]  data_byte;
        logic        data_last;
    } t_job;

    typedef enum logic [3:0] {
        STEP_OP,
        STEP_LEN,
        STEP_EXT_HI,
        STEP_EXT_LO,
        STEP_MASK0,
        STEP_MASK1,
        STEP_MASK2,
        STEP_MASK3,
        STEP_DATA
    } t_step;

endpackage

// File: hw/rtl/wsce_if.sv
// input and output channel interfaces of the websocket client frame encoder
// depends on nothing but the handshake convention valid and ready
interface wsce_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [3:0] opcode;
    logic [15:0] payload_length;
    logic [31:0] mask_key;
    logic       carries_byte;
    logic [7:0] data_byte;

    modport source (output valid, start_req, opcode, payload_length, mask_key,
                    carries_byte, data_byte, input ready);
    modport sink (input valid, start_req, opcode, payload_length, mask_key,
                  carries_byte, data_byte, output ready);
endinterface

interface wsce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// File: hw/rtl/wsce_front.sv
// front end: accepts items, tracks frame state, masks payload and queues jobs
// depends on wsce_pkg and wsce_in_if
module wsce_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsce_in_if.sink         i_item,
    input  logic            i_full,
    output logic            o_push,
    output wsce_pkg::t_job  o_job
);
    import wsce_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic [1:0]  r_pos, n_pos;
    logic [15:0] r_emitted, n_emitted;
    logic [15:0] r_total, n_total;
    logic [31:0] r_mask, n_mask;

    logic        w_accept;
    logic        w_ext;
    logic [16:0] w_total_raw;
    logic [15:0] w_total;
    logic [15:0] w_hdr;
    logic        w_in_frame;
    logic [1:0]  w_pos;
    logic [15:0] w_emitted;
    logic [15:0] w_tot;
    logic [31:0] w_mask;
    logic        w_data;
    logic [15:0] w_emitted_inc;
    logic [7:0]  w_mbyte;

    assign i_item.ready = !i_full;
    assign w_accept     = i_item.valid && !i_full;

    always_comb begin
        w_ext       = i_item.payload_length > LEN_SHORT_MAX;
        w_hdr       = w_ext ? HDR_EXT_BYTES : HDR_BYTES;
        w_total_raw = 17'(HDR_BYTES) + 17'(i_item.payload_length) + (w_ext ? 17'd2 : 17'd0);
        w_total     = (w_total_raw > 17'(MAX_FRAME_BYTES)) ? MAX_FRAME_BYTES
                                                            : w_total_raw[15:0];
        // frame state as seen by the payload part of this item
        if (i_item.start_req) begin
            w_in_frame = (w_total != w_hdr);
            w_pos      = 2'd0;
            w_emitted  = w_hdr;
            w_tot      = w_total;
            w_mask     = i_item.mask_key;
        end else begin
            w_in_frame = r_in_frame;
            w_pos      = r_pos;
            w_emitted  = r_emitted;
            w_tot      = r_total;
            w_mask     = r_mask;
        end
        w_data        = i_item.carries_byte && w_in_frame;
        w_emitted_inc = w_emitted + 16'd1;
        case (w_pos)
            2'd0:    w_mbyte = w_mask[31:24];
            2'd1:    w_mbyte = w_mask[23:16];
            2'd2:    w_mbyte = w_mask[15:8];
            default: w_mbyte = w_mask[7:0];
        endcase
    end

    always_comb begin
        n_in_frame = w_in_frame;
        n_pos      = w_pos;
        n_emitted  = w_emitted;
        n_total    = w_tot;
        n_mask     = w_mask;
        if (w_data) begin
            n_pos      = w_pos + 2'd1;
            n_emitted  = w_emitted_inc;
            n_in_frame = (w_emitted_inc != w_tot);
        end
    end

    always_comb begin
        o_push               = w_accept && (i_item.start_req || w_data);
        o_job.start          = i_item.start_req;
        o_job.opcode         = i_item.opcode;
        o_job.payload_length = i_item.payload_length;
        o_job.mask_key       = i_item.mask_key;
        o_job.ext            = w_ext;
        o_job.hdr_last       = (w_total == w_hdr);
        o_job.has_data       = w_data;
        o_job.data_byte      = i_item.data_byte ^ w_mbyte;
        o_job.data_last      = (w_emitted_inc == w_tot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 2'd0;
            r_emitted  <= 16'd0;
            r_total    <= 16'd0;
            r_mask     <= 32'd0;
        end else if (w_accept) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_emitted  <= n_emitted;
            r_total    <= n_total;
            r_mask     <= n_mask;
        end
    end

endmodule

// File: hw/rtl/wsce_queue.sv
// short job queue between front end and byte sequencer
// depends on wsce_pkg
module wsce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsce_pkg::t_job  i_job,
    input  logic            i_pop,
    output wsce_pkg::t_job  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import wsce_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// File: hw/rtl/wsce_back.sv
// byte sequencer: expands queued jobs into frame bytes behind an output register
// depends on wsce_pkg and wsce_out_if
module wsce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsce_pkg::t_job  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    wsce_out_if.source      o_frame
);
    import wsce_pkg::*;

    t_job       r_job;
    t_step      r_step, n_step;
    logic       r_busy;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       w_done;
    logic       w_advance;
    logic       w_next_job;
    logic [7:0] w_byte;
    logic       w_last;

    assign o_frame.valid    = r_out_valid;
    assign o_frame.out_byte = r_out_byte;
    assign o_frame.last     = r_out_last;

    assign w_advance  = !r_out_valid || o_frame.ready;
    assign w_next_job = !r_busy || w_done;
    assign o_pop      = w_advance && w_next_job && !i_empty;

    // next step
    always_comb begin
        n_step = r_step;
        w_done = 1'b0;
        case (r_step)
            STEP_OP:     n_step = STEP_LEN;
            STEP_LEN:    n_step = r_job.ext ? STEP_EXT_HI : STEP_MASK0;
            STEP_EXT_HI: n_step = STEP_EXT_LO;
            STEP_EXT_LO: n_step = STEP_MASK0;
            STEP_MASK0:  n_step = STEP_MASK1;
            STEP_MASK1:  n_step = STEP_MASK2;
            STEP_MASK2:  n_step = STEP_MASK3;
            STEP_MASK3: begin
                if (r_job.has_data) begin
                    n_step = STEP_DATA;
                end else begin
                    w_done = 1'b1;
                end
            end
            default:     w_done = 1'b1;
        endcase
    end

    // byte of the current step
    always_comb begin
        w_byte = 8'd0;
        w_last = 1'b0;
        case (r_step)
            STEP_OP:     w_byte = HDR_FLAG | {4'd0, r_job.opcode};
            STEP_LEN:    w_byte = {1'b1, r_job.ext ? LEN_EXT_CODE
                                                   : r_job.payload_length[6:0]};
            STEP_EXT_HI: w_byte = r_job.payload_length[15:8];
            STEP_EXT_LO: w_byte = r_job.payload_length[7:0];
            STEP_MASK0:  w_byte = r_job.mask_key[31:24];
            STEP_MASK1:  w_byte = r_job.mask_key[23:16];
            STEP_MASK2:  w_byte = r_job.mask_key[15:8];
            STEP_MASK3: begin
                w_byte = r_job.mask_key[7:0];
                w_last = r_job.hdr_last;
            end
            STEP_DATA: begin
                w_byte = r_job.data_byte;
                w_last = r_job.data_last;
            end
            default: begin
                w_byte = 8'd0;
                w_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_advance) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_OP;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_busy;
            if (w_next_job) begin
                r_busy <= !i_empty;
                r_step <= i_head.start ? STEP_OP : STEP_DATA;
            end else begin
                r_step <= n_step;
            end
        end
    end

    a_data_step_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == STEP_DATA) |-> r_job.has_data)
        else $error("payload step without payload byte");
    a_ext_step_is_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step == STEP_EXT_HI || r_step == STEP_EXT_LO)) |-> r_job.ext)
        else $error("extended length step on short frame");
    a_header_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step != STEP_DATA) |-> r_job.start)
        else $error("header step on job without start");

endmodule

// File: hw/rtl/websocket_client_frame_encoder.sv
// Masked client WebSocket frame encoder. An item with start_req set latches opcode,
// length and mask key and yields the header: 0x80|opcode, mask bit with 7-bit length
// or 126, a big-endian 16-bit length above 125 bytes, then the four mask bytes.
// Each payload item with a byte in an open frame yields one masked byte; frames are
// cut at MAX_FRAME_BYTES and the final byte carries last. Payload-only items are
// taken one per cycle while the job queue is not full; a start item takes the byte
// output for 6 or 8 header bytes (plus one for a payload byte in the same item); the
// sequencer emits one frame byte per cycle while the output is ready. A four-entry
// job queue lets new items be accepted while header bytes drain.
module websocket_client_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsce_in_if.sink    i_item,
    wsce_out_if.source o_frame
);
    import wsce_pkg::*;

    t_job w_push_job;
    t_job w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    wsce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    wsce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    wsce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_frame (o_frame)
    );

endmodule

// File: tb/sv/tb_websocket_client_frame_encoder.sv
// testbench of the websocket client frame encoder: directed and random frames through
// the item channel, a scoreboard predicting every frame byte and its last flag
// depends on wsce_pkg, the wsce_if interfaces and websocket_client_frame_encoder
module tb_websocket_client_frame_encoder;
    import wsce_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 480;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       last;
    } t_frame_byte;

    class frame_scoreboard;
        t_frame_byte exp_q[$];
        logic [15:0] payload_idx = '0;
        logic [15:0] sent_bytes  = '0;
        logic [15:0] frame_bytes = '0;
        logic [31:0] cur_mask    = '0;
        bit          frame_open  = 1'b0;
        int          errors      = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return exp_q.size();
        endfunction

        function void push_byte(logic [7:0] b);
            bit fin;
            if (!frame_open || sent_bytes >= frame_bytes) return;
            sent_bytes++;
            fin = (sent_bytes == frame_bytes);
            exp_q.push_back('{fbyte: b, last: fin});
            if (fin) frame_open = 1'b0;
        endfunction

        // returns 1 when the item does anything at all
        function bit note_item(bit start, logic [3:0] op, logic [15:0] len,
                               logic [31:0] key, bit carries, logic [7:0] data);
            int unsigned span;
            bit          ext;
            logic [31:0] key_shift;
            bit          used;
            used = start;
            if (start) begin
                ext  = (len > LEN_SHORT_MAX);
                span = 32'(HDR_BYTES) + 32'(len) + (ext ? 32'd2 : 32'd0);
                if (span > 32'(MAX_FRAME_BYTES)) span = 32'(MAX_FRAME_BYTES);
                frame_bytes = span[15:0];
                cur_mask    = key;
                payload_idx = '0;
                sent_bytes  = '0;
                frame_open  = (span != 0);
                push_byte(HDR_FLAG | {4'b0, op});
                push_byte(HDR_FLAG | {1'b0, ext ? LEN_EXT_CODE : len[6:0]});
                if (ext) begin
                    push_byte(len[15:8]);
                    push_byte(len[7:0]);
                end
                for (int k = 0; k < 4; k++) push_byte(cur_mask[31 - 8 * k -: 8]);
            end
            if (carries && frame_open) begin
                key_shift = cur_mask >> (24 - 8 * payload_idx[1:0]);
                push_byte(data ^ key_shift[7:0]);
                payload_idx++;
                used = 1'b1;
            end
            return used;
        endfunction

        task check_result(logic [7:0] b, logic l);
            t_frame_byte want;
            if (exp_q.size() == 0) begin
                report($sformatf("frame byte %02h last %0b with nothing expected", b, l));
                return;
            end
            want = exp_q.pop_front();
            if (b !== want.fbyte)
                report($sformatf("frame byte %02h, expected %02h", b, want.fbyte));
            if (l !== want.last)
                report($sformatf("last %0b on byte %02h, expected %0b", l, b, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    wsce_in_if  in_if ();
    wsce_out_if out_if ();

    websocket_client_frame_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_if),
        .o_frame (out_if)
    );

    frame_scoreboard sb;
    bit hold_req;
    int burst_left;
    int effective_items;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(bit start, logic [3:0] op, logic [15:0] len,
                             logic [31:0] key, bit carries, logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid          <= 1'b1;
        in_if.start_req      <= start;
        in_if.opcode         <= op;
        in_if.payload_length <= len;
        in_if.mask_key       <= key;
        in_if.carries_byte   <= carries;
        in_if.data_byte      <= data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        effective_items += sb.note_item(start, op, len, key, carries, data);
    endtask

    task automatic send_byte(logic [7:0] data);
        send_item(1'b0, 4'($urandom), 16'($urandom), $urandom, 1'b1, data);
    endtask

    // payload items, now and then one without a byte
    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++) begin
            send_item(1'b0, 4'($urandom), 16'($urandom), $urandom,
                      $urandom_range(0, 9) != 0, 8'($urandom));
        end
    endtask

    task automatic send_frame(logic [15:0] len, int n_bytes);
        bit with_byte;
        with_byte = $urandom_range(0, 1);
        send_item(1'b1, 4'($urandom), len, $urandom, with_byte, 8'($urandom));
        send_bytes(n_bytes - (with_byte ? 1 : 0));
    endtask

    initial begin
        int kind;
        int n;
        int shape;
        logic [15:0] len;
        sb = new;
        hold_req        = 1'b0;
        burst_left      = 0;
        effective_items = 0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.start_req      <= 1'b0;
        in_if.opcode         <= '0;
        in_if.payload_length <= '0;
        in_if.mask_key       <= '0;
        in_if.carries_byte   <= 1'b0;
        in_if.data_byte      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // payload byte while idle
        send_item(1'b0, OP_TEXT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        // zero length, the byte in the start item is dropped
        send_item(1'b1, OP_CONT, 16'd0, 32'hFFFF_FFFF, 1'b1, 8'hAA);
        send_item(1'b0, OP_CONT, 16'd0, 32'h0, 1'b1, 8'h55);
        // start carrying the only payload byte
        send_item(1'b1, OP_TEXT, 16'd1, 32'h0, 1'b1, 8'hFF);
        // longest short length, abandoned part way
        send_item(1'b1, OP_BINARY, 16'd125, 32'h1234_5678, 1'b0, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // shortest extended length, abandoned
        send_item(1'b1, OP_CLOSE, 16'd126, 32'hA5C3_0F81, 1'b1, 8'h00);
        send_byte(8'hC3);
        send_byte(8'h3C);
        // largest length, abandoned after the header and its first payload byte
        send_item(1'b1, OP_RSVD_F, 16'hFFFF, 32'h0, 1'b1, 8'hFF);
        // complete frame, then a byte past its end
        send_item(1'b1, OP_PING, 16'd3, $urandom, 1'b0, 8'h00);
        send_byte(8'h81);
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_item(1'b1, OP_PONG, 16'd127, $urandom, 1'b1, 8'($urandom));
        send_byte(8'($urandom));
        send_item(1'b1, OP_BINARY, 16'd2, $urandom, 1'b1, 8'($urandom));
        send_byte(8'($urandom));

        // receiver holds off while a frame streams in
        hold_req = 1'b1;
        send_frame(16'd40, 40);

        effective_items = 0;
        while (effective_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
            0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, 20));
            6, 7: len = 16'($urandom_range(120, 131));
            8: len = 16'($urandom_range(126, 300));
            default: len = 16'($urandom);
            endcase
            if (kind == 9) begin
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 7) == 0, 4'($urandom), 16'($urandom),
                              $urandom, $urandom_range(0, 1), 8'($urandom));
            end else begin
                shape = $urandom_range(0, 7);
                n = len;
                if (shape == 0) n = $urandom_range(0, len);
                else if (shape == 1) n = len + $urandom_range(1, 3);
                send_frame(len, n);
            end
        end

        // one frame cut at the size limit, with bytes offered past the cut
        len = 16'($urandom_range(1017, 1200));
        send_frame(len, len + 4);

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= (phase % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.out_byte, out_if.last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// File: sim.f
hw/rtl/wsce_pkg.sv
hw/rtl/wsce_if.sv
hw/rtl/wsce_front.sv
hw/rtl/wsce_queue.sv
hw/rtl/wsce_back.sv
hw/rtl/websocket_client_frame_encoder.sv
tb/sv/tb_websocket_client_frame_encoder.sv
